// File: hw/rtl/largest_empty_square_finder_top_macros.svh
// Assertion helpers for the checker file of the square finder.
`ifndef LARGEST_EMPTY_SQUARE_FINDER_TOP_MACROS_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_TOP_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define LESF_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LESF_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/lesf_pkg.sv
package lesf_pkg;

   // field widths of the stream words and registers
   localparam int CHAR_W     = 8;
   localparam int F_SIZE_W   = 11;
   localparam int F_ROW_W    = 12;
   localparam int F_COL_W    = 10;
   localparam int GW_W       = 11;
   localparam int GH_W       = 13;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 13;

   // response word layout, lowest field first
   localparam int OFS_CELL_SIZE = 0;
   localparam int OFS_BEST_ROW  = OFS_CELL_SIZE + F_SIZE_W;
   localparam int OFS_BEST_COL  = OFS_BEST_ROW + F_ROW_W;
   localparam int OFS_BEST_SIZE = OFS_BEST_COL + F_COL_W;
   localparam int RSP_USED_W    = OFS_BEST_SIZE + F_SIZE_W;
   localparam int RSP_DATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   // defaults
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam logic [CHAR_W-1:0] RST_EMPTY_CHAR  = 8'd46;
   localparam logic [GW_W-1:0]   RST_GRID_WIDTH  = 11'd1024;
   localparam logic [GH_W-1:0]   RST_GRID_HEIGHT = 13'd4096;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_EMPTY_CHAR  = 2'd0,
      CSR_GRID_WIDTH  = 2'd1,
      CSR_GRID_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CHAR_W-1:0] empty_char;
      logic [GW_W-1:0]   grid_width;
      logic [GH_W-1:0]   grid_height;
   } cfg_type;

   // word handed from the size cell to the best cell
   typedef struct packed {
      logic [F_SIZE_W-1:0] size;
      logic [F_ROW_W-1:0]  row;
      logic [F_COL_W-1:0]  col;
      logic                done;
   } cell_word_type;

endpackage

// File: hw/rtl/lesf_size_cell.sv
module lesf_size_cell #(
   parameter int MAX_WIDTH  = lesf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lesf_pkg::DEF_MAX_HEIGHT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lesf_pkg::cfg_type           cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [lesf_pkg::CHAR_W-1:0] in_char,
   output logic                        dn_valid,
   input  logic                        dn_ready,
   output lesf_pkg::cell_word_type     dn_word
);
   import lesf_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SW = $clog2(MAX_WIDTH + 1);
   localparam int XW = (CW + 1 > GW_W) ? CW + 1 : GW_W;
   localparam int YW = (RW + 1 > GH_W) ? RW + 1 : GH_W;

   logic [SW-1:0]  line_mem [MAX_WIDTH];
   logic [SW-1:0]  up_ff;
   logic [SW-1:0]  left_ff, left_in;
   logic [SW-1:0]  diag_ff, diag_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic           valid_ff, valid_in;
   cell_word_type  word_ff;

   logic           accept;
   logic           open_cell;
   logic [SW-1:0]  min_size;
   logic [SW-1:0]  size;
   logic [XW-1:0]  gw_x, last_ci;
   logic [YW-1:0]  gh_x, last_ri;
   logic           last_col, last_row, done;

   assign in_ready = !valid_ff || dn_ready;
   assign accept   = in_valid && in_ready;
   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

   // last column and row index after clamping the configured sizes
   always_comb begin
      gw_x = XW'(cfg.grid_width);
      gh_x = YW'(cfg.grid_height);
      if (gw_x == '0) begin
         last_ci = '0;
      end else if (gw_x > XW'(MAX_WIDTH)) begin
         last_ci = XW'(MAX_WIDTH - 1);
      end else begin
         last_ci = gw_x - 1'b1;
      end
      if (gh_x == '0) begin
         last_ri = '0;
      end else if (gh_x > YW'(MAX_HEIGHT)) begin
         last_ri = YW'(MAX_HEIGHT - 1);
      end else begin
         last_ri = gh_x - 1'b1;
      end
      last_col = XW'(col_ff) >= last_ci;
      last_row = YW'(row_ff) >= last_ri;
      done     = last_col && last_row;
   end

   // square recurrence: left, up and diagonal neighbors
   always_comb begin
      open_cell = (in_char == cfg.empty_char);
      min_size  = left_ff;
      if (up_ff < min_size) begin
         min_size = up_ff;
      end
      if (diag_ff < min_size) begin
         min_size = diag_ff;
      end
      if (!open_cell) begin
         size = '0;
      end else if (row_ff == '0 || col_ff == '0) begin
         size = SW'(1);
      end else begin
         size = min_size + 1'b1;
      end
   end

   // position and neighbor update
   always_comb begin
      valid_in = accept || (valid_ff && !dn_ready);
      col_in   = col_ff;
      row_in   = row_ff;
      left_in  = left_ff;
      diag_in  = diag_ff;
      if (accept) begin
         if (done) begin
            col_in  = '0;
            row_in  = '0;
            left_in = '0;
            diag_in = '0;
         end else if (last_col) begin
            col_in  = '0;
            row_in  = row_ff + 1'b1;
            left_in = '0;
            diag_in = '0;
         end else begin
            col_in  = col_ff + 1'b1;
            left_in = size;
            diag_in = up_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         col_ff   <= '0;
         row_ff   <= '0;
         left_ff  <= '0;
         diag_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         left_ff  <= left_in;
         diag_ff  <= diag_in;
      end
   end

   // line buffer: write this column, prefetch the next one
   always_ff @(posedge clock) begin
      if (accept) begin
         line_mem[col_ff] <= size;
         if (col_in == col_ff) begin
            up_ff <= size;
         end else begin
            up_ff <= line_mem[col_in];
         end
         word_ff.size <= F_SIZE_W'(size);
         word_ff.row  <= F_ROW_W'(row_ff);
         word_ff.col  <= F_COL_W'(col_ff);
         word_ff.done <= done;
      end
   end

endmodule

// File: hw/rtl/lesf_best_cell.sv
module lesf_best_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            up_valid,
   output logic                            up_ready,
   input  lesf_pkg::cell_word_type         up_word,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lesf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import lesf_pkg::*;

   logic [F_SIZE_W-1:0] best_size_ff, best_size_in;
   logic [F_ROW_W-1:0]  best_row_ff, best_row_in;
   logic [F_COL_W-1:0]  best_col_ff, best_col_in;
   logic                out_valid_ff, out_valid_in;
   logic [F_SIZE_W-1:0] cell_size_ff;
   logic [F_SIZE_W-1:0] out_size_ff;
   logic [F_ROW_W-1:0]  out_row_ff;
   logic [F_COL_W-1:0]  out_col_ff;
   logic                out_last_ff;

   logic                take;
   logic [F_SIZE_W-1:0] new_size;
   logic [F_ROW_W-1:0]  new_row;
   logic [F_COL_W-1:0]  new_col;

   assign up_ready = !out_valid_ff || rsp_tready;
   assign take     = up_valid && up_ready;

   // keep the first strictly larger square
   always_comb begin
      new_size = best_size_ff;
      new_row  = best_row_ff;
      new_col  = best_col_ff;
      if (up_word.size > best_size_ff) begin
         new_size = up_word.size;
         new_row  = up_word.row;
         new_col  = up_word.col;
      end
      out_valid_in = take || (out_valid_ff && !rsp_tready);
      best_size_in = best_size_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      if (take) begin
         if (up_word.done) begin
            best_size_in = '0;
            best_row_in  = '0;
            best_col_in  = '0;
         end else begin
            best_size_in = new_size;
            best_row_in  = new_row;
            best_col_in  = new_col;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         best_size_ff <= '0;
         best_row_ff  <= '0;
         best_col_ff  <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         best_size_ff <= best_size_in;
         best_row_ff  <= best_row_in;
         best_col_ff  <= best_col_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (take) begin
         cell_size_ff <= up_word.size;
         out_size_ff  <= new_size;
         out_row_ff   <= new_row;
         out_col_ff   <= new_col;
         out_last_ff  <= up_word.done;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_USED_W)'(0), out_size_ff, out_col_ff, out_row_ff,
                        cell_size_ff};

endmodule

// File: hw/rtl/largest_empty_square_finder_top.sv
// Largest empty square finder: one map character in, one result word out.
// An accepted req word is registered in the size cell, then in the best cell's output register.
// Throughput: one word per cycle while rsp_tready does not stall the output, set by the size
// recurrence through the left-size register; the line buffer read is prefetched one column ahead.
// Reset: synchronous; clears position, neighbors and best square, loads the
// register defaults; the line buffer is not cleared (row 0 never reads it).
module largest_empty_square_finder_top #(
   parameter int MAX_WIDTH  = lesf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lesf_pkg::DEF_MAX_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   // cell_char[7:0]
   input  logic [7:0]                        req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // cell_size[10:0], best_row[22:11], best_col[32:23], best_size[43:33], zero fill
   output logic [lesf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // grid_done
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wen,
   input  logic [lesf_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [lesf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lesf_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          mid_valid;
   logic          mid_ready;
   cell_word_type mid_word;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            CSR_EMPTY_CHAR:  cfg_in.empty_char  = csr_wdata[CHAR_W-1:0];
            CSR_GRID_WIDTH:  cfg_in.grid_width  = csr_wdata[GW_W-1:0];
            CSR_GRID_HEIGHT: cfg_in.grid_height = csr_wdata[GH_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.empty_char  <= RST_EMPTY_CHAR;
         cfg_ff.grid_width  <= RST_GRID_WIDTH;
         cfg_ff.grid_height <= RST_GRID_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lesf_size_cell #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_size (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_char  (req_tdata),
      .dn_valid (mid_valid),
      .dn_ready (mid_ready),
      .dn_word  (mid_word)
   );

   lesf_best_cell u_best (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (mid_valid),
      .up_ready   (mid_ready),
      .up_word    (mid_word),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: hw/rtl/lesf_checker.sv
`include "largest_empty_square_finder_top_macros.svh"

module lesf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lesf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import lesf_pkg::*;

   logic [F_SIZE_W-1:0] cell_size;
   logic [F_ROW_W-1:0]  best_row;
   logic [F_COL_W-1:0]  best_col;
   logic [F_SIZE_W-1:0] best_size;

   assign cell_size = rsp_tdata[OFS_CELL_SIZE +: F_SIZE_W];
   assign best_row  = rsp_tdata[OFS_BEST_ROW +: F_ROW_W];
   assign best_col  = rsp_tdata[OFS_BEST_COL +: F_COL_W];
   assign best_size = rsp_tdata[OFS_BEST_SIZE +: F_SIZE_W];

   // a stalled word holds
   `LESF_ASSERT_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp word changed while stalled")
   // best square covers the current cell's square
   `LESF_ASSERT_RST(a_best_covers, clock, reset, rsp_tvalid |-> best_size >= cell_size, "best size below cell size")
   // no square yet means the origin corner
   `LESF_ASSERT_RST(a_empty_origin, clock, reset, rsp_tvalid && best_size == '0 |-> best_row == '0 && best_col == '0, "empty best not at origin")
   // nothing left over from before reset
   `LESF_ASSERT(a_reset_idle, clock, reset |=> !rsp_tvalid, "rsp valid right after reset")

endmodule

bind largest_empty_square_finder_top lesf_checker u_lesf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// File: tb/sv/square_finder_checker.sv
module square_finder_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [7:0]                       req_tdata,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [lesf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tlast,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_wen,
   input  logic [lesf_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [lesf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               mismatches,
   output int                               outstanding,
   output int                               words_checked,
   output int                               grids_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import lesf_pkg::*;

   localparam int MAX_W = DEF_MAX_WIDTH;
   localparam int MAX_H = DEF_MAX_HEIGHT;

   typedef struct {
      logic [F_SIZE_W-1:0] cell_size;
      logic [F_ROW_W-1:0]  best_row;
      logic [F_COL_W-1:0]  best_col;
      logic [F_SIZE_W-1:0] best_size;
      logic                grid_done;
   } square_word_type;

   // configuration copy
   logic [CHAR_W-1:0]   empty_char_q;
   logic [GW_W-1:0]     grid_width_q;
   logic [GH_W-1:0]     grid_height_q;

   // scan state of the model
   logic [F_SIZE_W-1:0] line_sizes [MAX_W];
   logic [F_SIZE_W-1:0] left_q;
   logic [F_SIZE_W-1:0] diag_q;
   logic [F_ROW_W-1:0]  row_q;
   logic [F_COL_W-1:0]  col_q;
   logic [F_ROW_W-1:0]  best_row_q;
   logic [F_COL_W-1:0]  best_col_q;
   logic [F_SIZE_W-1:0] best_size_q;

   square_word_type expected_words[$];

   function automatic void clear_scan();
      left_q      = '0;
      diag_q      = '0;
      row_q       = '0;
      col_q       = '0;
      best_row_q  = '0;
      best_col_q  = '0;
      best_size_q = '0;
   endfunction

   // one map cell: square size here, running best, end of grid
   function automatic square_word_type next_square_word(input logic [CHAR_W-1:0] ch);
      square_word_type     w;
      int                  width_eff;
      int                  height_eff;
      logic [F_SIZE_W-1:0] up;
      logic [F_SIZE_W-1:0] size;
      logic                last_col;
      width_eff  = (grid_width_q == 0) ? 1 :
                   (int'(grid_width_q) > MAX_W) ? MAX_W : int'(grid_width_q);
      height_eff = (grid_height_q == 0) ? 1 :
                   (int'(grid_height_q) > MAX_H) ? MAX_H : int'(grid_height_q);
      up = line_sizes[col_q];
      if (ch != empty_char_q) begin
         size = '0;
      end else if (row_q == 0 || col_q == 0) begin
         size = F_SIZE_W'(1);
      end else begin
         size = left_q;
         if (up < size) size = up;
         if (diag_q < size) size = diag_q;
         size = size + 1'b1;
      end
      line_sizes[col_q] = size;
      diag_q = up;
      left_q = size;
      // strict compare keeps the earliest of equal squares
      if (size > best_size_q) begin
         best_size_q = size;
         best_row_q  = row_q;
         best_col_q  = col_q;
      end
      last_col    = (int'(col_q) >= width_eff - 1);
      w.grid_done = last_col && (int'(row_q) >= height_eff - 1);
      w.cell_size = size;
      w.best_row  = best_row_q;
      w.best_col  = best_col_q;
      w.best_size = best_size_q;
      if (w.grid_done) begin
         clear_scan();
      end else if (last_col) begin
         col_q  = '0;
         row_q  = row_q + 1'b1;
         left_q = '0;
         diag_q = '0;
      end else begin
         col_q = col_q + 1'b1;
      end
      return w;
   endfunction

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      square_word_type exp_word;
      if (reset) begin
         empty_char_q  = RST_EMPTY_CHAR;
         grid_width_q  = RST_GRID_WIDTH;
         grid_height_q = RST_GRID_HEIGHT;
         for (int i = 0; i < MAX_W; i++) line_sizes[i] = '0;
         clear_scan();
         expected_words.delete();
         mismatches    = 0;
         words_checked = 0;
         grids_seen    = 0;
      end else begin
         // register writes must land only while the block is idle; the block does not enforce it
         if (csr_wen) begin
            case (csr_index_type'(csr_addr))
               CSR_EMPTY_CHAR:  empty_char_q  = csr_wdata[CHAR_W-1:0];
               CSR_GRID_WIDTH:  grid_width_q  = csr_wdata[GW_W-1:0];
               CSR_GRID_HEIGHT: grid_height_q = csr_wdata[GH_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_words.push_back(next_square_word(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $error("result word with no map cell pending");
               mismatches++;
            end else begin
               exp_word = expected_words.pop_front();
               check_field("cell_size", exp_word.cell_size,
                           rsp_tdata[OFS_CELL_SIZE +: F_SIZE_W]);
               check_field("best_row", exp_word.best_row,
                           rsp_tdata[OFS_BEST_ROW +: F_ROW_W]);
               check_field("best_col", exp_word.best_col,
                           rsp_tdata[OFS_BEST_COL +: F_COL_W]);
               check_field("best_size", exp_word.best_size,
                           rsp_tdata[OFS_BEST_SIZE +: F_SIZE_W]);
               check_field("grid_done", exp_word.grid_done, rsp_tlast);
               words_checked++;
               if (exp_word.grid_done) grids_seen++;
            end
         end
      end
      outstanding <= expected_words.size();
   end

endmodule

// File: tb/sv/tb_largest_empty_square_finder_top.sv
module tb_largest_empty_square_finder_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lesf_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int LATENCY       = 2;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_CELLS   = 60;
   localparam logic [7:0] DOT   = RST_EMPTY_CHAR;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [7:0]             req_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_wen    = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int  mismatches;
   int  outstanding;
   int  words_checked;
   int  grids_seen;
   int  cycle_count   = 0;
   int  cells_sent    = 0;
   int  csr_writes    = 0;
   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   int  hold_cnt      = 0;
   bit  hold_pending  = 1'b0;

   largest_empty_square_finder_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   square_finder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .csr_wen       (csr_wen),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .words_checked (words_checked),
      .grids_seen    (grids_seen)
   );

   always #10 clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_pending) begin
         hold_pending = 1'b0;
         hold_cnt     = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // register write, called at a falling edge, returns at a falling edge
   task automatic csr_write(input csr_index_type idx, input int value);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
      csr_writes++;
   endtask

   // offer one map cell; tvalid stays high on return for back-to-back words
   task automatic send_cell(input logic [7:0] ch);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      cells_sent++;
   endtask

   // stop offering, wait for every pending result, then let the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_cell_char(input logic [7:0] open_char,
                                                input int open_pct);
      logic [7:0] ch;
      ch = $urandom_range(255);
      if ($urandom_range(99) < open_pct) ch = open_char;
      return ch;
   endfunction

   task automatic send_cells(input int count, input logic [7:0] open_char,
                             input int open_pct);
      for (int i = 0; i < count; i++) send_cell(pick_cell_char(open_char, open_pct));
   endtask

   function automatic int pick_dim();
      int d;
      d = $urandom_range(1, 12);
      if ($urandom_range(7) == 0) d = $urandom_range(13, 40);
      if ($urandom_range(19) == 0) d = 0;
      return d;
   endfunction

   // random grids under one traffic profile; some grids get resized mid-way
   task automatic run_traffic_phase(input int idle_pct, input int stall_pct,
                                    input bit with_hold);
      int         start_cells;
      int         w_val, h_val, w_eff, h_eff;
      int         rows_done, w2, h2;
      int         open_pct;
      logic [7:0] open_char;
      start_cells   = cells_sent;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      while (cells_sent - start_cells < PHASE_CELLS) begin
         drain();
         open_char = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : DOT;
         case ($urandom_range(3))
            0:       open_pct = 50;
            1:       open_pct = 80;
            2:       open_pct = 95;
            default: open_pct = 100;
         endcase
         w_val = pick_dim();
         h_val = pick_dim();
         w_eff = (w_val == 0) ? 1 : w_val;
         h_eff = (h_val == 0) ? 1 : h_val;
         csr_write(CSR_EMPTY_CHAR, open_char);
         csr_write(CSR_GRID_WIDTH, w_val);
         csr_write(CSR_GRID_HEIGHT, h_val);
         if (with_hold && cells_sent == start_cells) hold_pending = 1'b1;
         if (h_eff > 1 && $urandom_range(7) == 0) begin
            // resize at a row boundary; a new height at or below the current
            // row ends the grid on this row
            rows_done = $urandom_range(1, h_eff - 1);
            send_cells(rows_done * w_eff, open_char, open_pct);
            drain();
            w2 = $urandom_range(1, 16);
            h2 = $urandom_range(1, rows_done + 4);
            csr_write(CSR_GRID_WIDTH, w2);
            csr_write(CSR_GRID_HEIGHT, h2);
            send_cells((h2 > rows_done) ? (h2 - rows_done) * w2 : w2, open_char, open_pct);
         end else begin
            send_cells(w_eff * h_eff, open_char, open_pct);
         end
      end
      drain();
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // one full-width row fills every line buffer entry
      csr_write(CSR_EMPTY_CHAR, DOT);
      csr_write(CSR_GRID_WIDTH, DEF_MAX_WIDTH);
      csr_write(CSR_GRID_HEIGHT, 1);
      send_cells(DEF_MAX_WIDTH, DOT, 90);
      drain();

      // fully open 3x3: sizes grow to 3, first size-1 and size-2 win ties
      csr_write(CSR_GRID_WIDTH, 3);
      csr_write(CSR_GRID_HEIGHT, 3);
      send_cells(9, DOT, 100);
      drain();

      // no open cell: best stays size 0 at the origin
      csr_write(CSR_GRID_WIDTH, 2);
      csr_write(CSR_GRID_HEIGHT, 2);
      send_cell(8'h00);
      send_cell(8'hFF);
      send_cell(DOT + 8'd1);
      send_cell(DOT - 8'd1);
      drain();

      // extreme open characters, with a tie on one row
      csr_write(CSR_EMPTY_CHAR, 8'h00);
      csr_write(CSR_GRID_WIDTH, 1);
      csr_write(CSR_GRID_HEIGHT, 2);
      send_cell(8'h00);
      send_cell(8'hFF);
      drain();
      csr_write(CSR_EMPTY_CHAR, 8'hFF);
      csr_write(CSR_GRID_WIDTH, 3);
      csr_write(CSR_GRID_HEIGHT, 1);
      send_cell(8'hFF);
      send_cell(8'hFF);
      send_cell(8'h00);
      drain();

      // zero sizes act as one
      csr_write(CSR_GRID_WIDTH, 0);
      csr_write(CSR_GRID_HEIGHT, 0);
      send_cell(8'hFF);
      drain();

      // oversize width clamps; shrinking mid-row and mid-grid ends both
      csr_write(CSR_EMPTY_CHAR, DOT);
      csr_write(CSR_GRID_WIDTH, 2047);
      csr_write(CSR_GRID_HEIGHT, DEF_MAX_HEIGHT);
      send_cells(3, DOT, 100);
      drain();
      csr_write(CSR_GRID_WIDTH, 2);
      csr_write(CSR_GRID_HEIGHT, 1);
      send_cell(DOT);
      drain();
      csr_write(CSR_GRID_HEIGHT, 8191);
      csr_write(CSR_GRID_HEIGHT, 1);

      run_traffic_phase(0, 0, 1'b1);
      run_traffic_phase(64, 0, 1'b0);
      run_traffic_phase(0, 64, 1'b0);
      run_traffic_phase(16, 16, 1'b1);
      drain();

      $display("Sent %0d map cells with %0d register writes over four traffic phases.",
               cells_sent, csr_writes);
      $display("Compared %0d result words, %0d of them closing a grid.",
               words_checked, grids_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: largest_empty_square_finder_top.f
+incdir+hw/rtl
hw/rtl/lesf_pkg.sv
hw/rtl/lesf_size_cell.sv
hw/rtl/lesf_best_cell.sv
hw/rtl/largest_empty_square_finder_top.sv
hw/rtl/lesf_checker.sv
tb/sv/square_finder_checker.sv
tb/sv/tb_largest_empty_square_finder_top.sv
